/* rtl/core/sior_pkg.sv */
// Package for the super I/O configuration register block.
// Holds port and register codes, reset tables and the structs passed between modules.
// No dependencies.
package sior_pkg;

    localparam int NUM_DEVICES_DEF = 8;
    localparam int MAIN_REG_COUNT  = 256;
    localparam int MAIN_AW         = $clog2(MAIN_REG_COUNT);

    // Access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Decoded I/O ports
    localparam logic [15:0] PORT_MAIN_INDEX = 16'h0108;
    localparam logic [15:0] PORT_MAIN_DATA  = 16'h0109;
    localparam logic [15:0] PORT_PNP_INDEX  = 16'h0279;
    localparam logic [15:0] PORT_PNP_WDATA  = 16'h0A79;
    localparam logic [15:0] PORT_PNP_RDATA  = 16'h03E3;

    // Key values on the main index port
    localparam logic [7:0] KEY_UNLOCK = 8'hAA;
    localparam logic [7:0] KEY_LOCK   = 8'h55;

    // Main register that gates the plug-and-play ports, and its gate bit
    localparam logic [MAIN_AW-1:0] REG_PNP_CTRL = 8'hC1;
    localparam int                 PNP_LIVE_BIT = 7;

    localparam logic [7:0] BYTE_NONE = 8'hFF;

    // Plug-and-play register indexes
    localparam logic [7:0] PNP_SELECT  = 8'h07;
    localparam logic [7:0] PNP_ENABLE  = 8'h30;
    localparam logic [7:0] PNP_ADDR_HI = 8'h60;
    localparam logic [7:0] PNP_ADDR_LO = 8'h61;
    localparam logic [7:0] PNP_IRQ     = 8'h70;
    localparam logic [7:0] PNP_DMA     = 8'h74;

    // Routed devices
    localparam logic [2:0] DEV_FLOPPY      = 3'd0;
    localparam logic [2:0] DEV_LAST_ROUTED = 3'd3;

    typedef struct packed {
        logic       data_wr;
        logic [7:0] index;
        logic [7:0] data;
    } sior_pnp_cmd_t;

    typedef struct packed {
        logic        fire;
        logic [2:0]  device;
        logic        enable;
        logic [15:0] addr;
        logic [7:0]  irq;
    } sior_reconf_t;

    function automatic logic [7:0] dev_reset_enable(input int i);
        logic [7:0] r;
        r = (i < 4) ? 8'h01 : 8'h00;
        return r;
    endfunction

    function automatic logic [15:0] dev_reset_base(input int i);
        logic [15:0] r;
        case (i)
            0:       r = 16'h03F0;
            1:       r = 16'h03F8;
            2:       r = 16'h02F8;
            3:       r = 16'h0378;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dev_reset_irq(input int i);
        logic [7:0] r;
        case (i)
            0:       r = 8'd6;
            1:       r = 8'd4;
            2:       r = 8'd3;
            3:       r = 8'd7;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dev_reset_dma(input int i);
        logic [7:0] r;
        r = (i == 0) ? 8'd2 : 8'd0;
        return r;
    endfunction

endpackage

/* rtl/core/sior_req_if.sv */
// Request channel: one bus access word per handshake.
// No dependencies.
interface sior_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] io_port;
    logic [7:0]  write_data;

    modport source (output valid, mode, io_port, write_data, input ready);
    modport sink   (input valid, mode, io_port, write_data, output ready);
endinterface

/* rtl/core/sior_rsp_if.sv */
// Response channel: one result word per access.
// No dependencies.
interface sior_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        claimed;
    logic        reconfig;
    logic [2:0]  reconfig_device;
    logic        reconfig_enable;
    logic [15:0] reconfig_addr;
    logic [7:0]  reconfig_irq;

    modport source (output valid, read_data, claimed, reconfig, reconfig_device,
                    reconfig_enable, reconfig_addr, reconfig_irq, input ready);
    modport sink   (input valid, read_data, claimed, reconfig, reconfig_device,
                    reconfig_enable, reconfig_addr, reconfig_irq, output ready);
endinterface

/* rtl/core/sior_main_regs.sv */
// Main byte register file: memory with a write port, a registered read port and per-entry valid bits.
// Depends on sior_pkg.
module sior_main_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [sior_pkg::MAIN_AW-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic [sior_pkg::MAIN_AW-1:0] raddr,
    input  logic                       idx_change,
    output logic [7:0]                 cur_data,
    output logic                       live
);
    import sior_pkg::*;

    logic [7:0]                mem [MAIN_REG_COUNT];
    logic [MAIN_REG_COUNT-1:0] valid_reg;
    logic [7:0]                rd_reg;
    logic                      rd_valid_reg;
    logic                      byp_flag_reg;
    logic [7:0]                byp_data_reg;
    logic                      live_reg;

    // Memory: write at the current index, prefetch at the next one
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            byp_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_flag_reg <= 1'b0;
            live_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[raddr];
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
                byp_flag_reg     <= 1'b1;
                if (waddr == REG_PNP_CTRL)
                begin
                    live_reg <= wdata[PNP_LIVE_BIT];
                end
            end
            else if (idx_change)
            begin
                byp_flag_reg <= 1'b0;
            end
        end
    end

    // Fresh write wins over the stale prefetch; unwritten entries read as zero
    assign cur_data = byp_flag_reg ? byp_data_reg : (rd_valid_reg ? rd_reg : 8'h00);
    assign live     = live_reg;

endmodule

/* rtl/core/sior_dev_bank.sv */
// Plug-and-play device bank: device select and per-device settings.
// Depends on sior_pkg.
module sior_dev_bank #(
    parameter int NUM_DEVICES = sior_pkg::NUM_DEVICES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sior_pkg::sior_pnp_cmd_t cmd,
    output logic [7:0]             rd_data,
    output sior_pkg::sior_reconf_t reconf
);
    import sior_pkg::*;

    localparam int DEV_W = $clog2(NUM_DEVICES);

    logic [2:0]  sel_reg;
    logic [7:0]  en_reg   [NUM_DEVICES];
    logic [15:0] base_reg [NUM_DEVICES];
    logic [7:0]  irq_reg  [NUM_DEVICES];
    logic [7:0]  dma_reg  [NUM_DEVICES];

    logic [DEV_W-1:0] dev;
    logic             dev_ok;
    logic [7:0]       cur_en, cur_irq, cur_dma, new_en, new_irq, new_dma, diff;
    logic [15:0]      cur_base, new_base;
    logic             fire;

    always_comb
    begin
        dev      = sel_reg[DEV_W-1:0];
        dev_ok   = int'(sel_reg) < NUM_DEVICES;
        cur_en   = en_reg[dev];
        cur_base = base_reg[dev];
        cur_irq  = irq_reg[dev];
        cur_dma  = dma_reg[dev];
        new_en   = cur_en;
        new_base = cur_base;
        new_irq  = cur_irq;
        new_dma  = cur_dma;
        diff     = 8'h00;
        case (cmd.index)
            PNP_ENABLE:
            begin
                new_en = cmd.data;
                diff   = cur_en ^ cmd.data;
            end
            PNP_ADDR_HI:
            begin
                new_base = {cmd.data, cur_base[7:0]};
                diff     = cur_base[15:8] ^ cmd.data;
            end
            PNP_ADDR_LO:
            begin
                new_base = {cur_base[15:8], cmd.data};
                diff     = cur_base[7:0] ^ cmd.data;
            end
            PNP_IRQ:
            begin
                new_irq = cmd.data;
                diff    = cur_irq ^ cmd.data;
            end
            PNP_DMA:
            begin
                new_dma = cmd.data;
                diff    = cur_dma ^ cmd.data;
            end
            default:
            begin
                diff = 8'h00;
            end
        endcase

        // Read-back
        if (cmd.index == PNP_SELECT)
        begin
            rd_data = {5'b0, sel_reg};
        end
        else if (!dev_ok)
        begin
            rd_data = BYTE_NONE;
        end
        else
        begin
            case (cmd.index)
                PNP_ENABLE:  rd_data = cur_en;
                PNP_ADDR_HI: rd_data = cur_base[15:8];
                PNP_ADDR_LO: rd_data = cur_base[7:0];
                PNP_IRQ:     rd_data = cur_irq;
                PNP_DMA:     rd_data = cur_dma;
                default:     rd_data = BYTE_NONE;
            endcase
        end

        // Floppy reroutes only on an enable change; devices 1 to 3 on any change; higher devices never reroute
        fire = cmd.data_wr && dev_ok && (cmd.index != PNP_SELECT) && (diff != 8'h00)
            && ((sel_reg == DEV_FLOPPY) ? (cmd.index == PNP_ENABLE)
                                         : (sel_reg <= DEV_LAST_ROUTED));

        reconf.fire   = fire;
        reconf.device = fire ? sel_reg : 3'd0;
        reconf.enable = fire ? new_en[0] : 1'b0;
        reconf.addr   = fire ? new_base : 16'h0000;
        reconf.irq    = fire ? new_irq : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= DEV_FLOPPY;
            for (int i = 0; i < NUM_DEVICES; i++)
            begin
                en_reg[i]   <= dev_reset_enable(i);
                base_reg[i] <= dev_reset_base(i);
                irq_reg[i]  <= dev_reset_irq(i);
                dma_reg[i]  <= dev_reset_dma(i);
            end
        end
        else if (cmd.data_wr)
        begin
            if (cmd.index == PNP_SELECT)
            begin
                sel_reg <= cmd.data[2:0];
            end
            else if (dev_ok)
            begin
                en_reg[dev]   <= new_en;
                base_reg[dev] <= new_base;
                irq_reg[dev]  <= new_irq;
                dma_reg[dev]  <= new_dma;
            end
        end
    end

endmodule

/* rtl/core/super_io_config_register_block.sv */
// Super I/O configuration registers with a plug-and-play extension. Each request word is one
// bus read or write; each gives exactly one response word. Ports 0x108/0x109 form a key-locked
// index/data pair (0xAA unlocks, 0x55 locks) onto 256 byte registers, cleared at reset through
// per-entry valid bits, so there is no clearing pass. While bit 7 of register 0xC1 is set,
// ports 0x279, 0xA79 and 0x3E3 reach the device select and per-device settings; a data write
// that changes a routed device (the floppy: only its enable) returns reconfig with its new
// settings. The block takes one access every cycle while responses are taken; an access
// passes an input register then a result register. The main register file has a write port
// and a registered read port: the next index is prefetched, and a bypass serves a fresh write.
// Depends on sior_pkg, sior_req_if, sior_rsp_if, sior_main_regs and sior_dev_bank.
module super_io_config_register_block #(
    parameter int NUM_DEVICES = sior_pkg::NUM_DEVICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sior_req_if.sink   req,
    sior_rsp_if.source rsp
);
    import sior_pkg::*;

    // Input register
    logic        s1_valid_reg;
    logic        s1_mode_reg;
    logic [15:0] s1_port_reg;
    logic [7:0]  s1_data_reg;

    // Architectural state
    logic               locked_reg, locked_next;
    logic [MAIN_AW-1:0] main_index_reg, main_index_next;
    logic [7:0]         pnp_index_reg, pnp_index_next;

    // Result register
    logic         out_valid_reg;
    logic [7:0]   out_rd_reg, out_rd_next;
    logic         out_claimed_reg, out_claimed_next;
    sior_reconf_t out_reconf_reg, out_reconf_next;

    logic          advance, proc;
    logic          is_write;
    logic          mem_we;
    logic [7:0]    cur_data;
    logic          pnp_live;
    sior_pnp_cmd_t pnp_cmd;
    logic [7:0]    pnp_rd;
    sior_reconf_t  bank_reconf;

    // The result slot frees when empty or taken; the input slot moves whenever it can
    assign advance   = !out_valid_reg || rsp.ready;
    assign proc      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign is_write  = (s1_mode_reg == MODE_WRITE);

    sior_main_regs u_main (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (mem_we),
        .waddr      (main_index_reg),
        .wdata      (s1_data_reg),
        .raddr      (main_index_next),
        .idx_change (main_index_next != main_index_reg),
        .cur_data   (cur_data),
        .live       (pnp_live)
    );

    sior_dev_bank #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pnp_cmd),
        .rd_data (pnp_rd),
        .reconf  (bank_reconf)
    );

    // Decode the word in the input register against the current state
    always_comb
    begin
        locked_next      = locked_reg;
        main_index_next  = main_index_reg;
        pnp_index_next   = pnp_index_reg;
        mem_we           = 1'b0;
        out_rd_next      = BYTE_NONE;
        out_claimed_next = 1'b0;
        out_reconf_next  = '0;
        pnp_cmd.data_wr  = 1'b0;
        pnp_cmd.index    = pnp_index_reg;
        pnp_cmd.data     = s1_data_reg;

        if (s1_port_reg == PORT_MAIN_INDEX || s1_port_reg == PORT_MAIN_DATA)
        begin
            out_claimed_next = 1'b1;
            if (is_write)
            begin
                if (locked_reg)
                begin
                    // Locked: only the unlock key on the index port counts
                    if (s1_port_reg == PORT_MAIN_INDEX && s1_data_reg == KEY_UNLOCK)
                    begin
                        locked_next = 1'b0;
                    end
                end
                else if (s1_port_reg == PORT_MAIN_INDEX)
                begin
                    if (s1_data_reg == KEY_LOCK)
                    begin
                        locked_next = 1'b1;
                    end
                    else
                    begin
                        main_index_next = s1_data_reg[MAIN_AW-1:0];
                    end
                end
                else
                begin
                    mem_we = proc;
                end
            end
            else if (!locked_reg)
            begin
                out_rd_next = (s1_port_reg == PORT_MAIN_INDEX) ? 8'(main_index_reg) : cur_data;
            end
        end
        else if (pnp_live)
        begin
            if (is_write && s1_port_reg == PORT_PNP_INDEX)
            begin
                out_claimed_next = 1'b1;
                pnp_index_next   = s1_data_reg;
            end
            else if (is_write && s1_port_reg == PORT_PNP_WDATA)
            begin
                out_claimed_next = 1'b1;
                pnp_cmd.data_wr  = proc;
                out_reconf_next  = bank_reconf;
            end
            else if (!is_write && s1_port_reg == PORT_PNP_RDATA)
            begin
                out_claimed_next = 1'b1;
                out_rd_next      = pnp_rd;
            end
        end

        // Hold state unless this word is really processed
        if (!proc)
        begin
            locked_next     = locked_reg;
            main_index_next = main_index_reg;
            pnp_index_next  = pnp_index_reg;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_mode_reg <= req.mode;
            s1_port_reg <= req.io_port;
            s1_data_reg <= req.write_data;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_rd_reg      <= out_rd_next;
            out_claimed_reg <= out_claimed_next;
            out_reconf_reg  <= out_reconf_next;
        end
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            locked_reg     <= 1'b1;
            main_index_reg <= '0;
            pnp_index_reg  <= 8'h00;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            locked_reg     <= locked_next;
            main_index_reg <= main_index_next;
            pnp_index_reg  <= pnp_index_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.read_data       = out_rd_reg;
    assign rsp.claimed         = out_claimed_reg;
    assign rsp.reconfig        = out_reconf_reg.fire;
    assign rsp.reconfig_device = out_reconf_reg.device;
    assign rsp.reconfig_enable = out_reconf_reg.enable;
    assign rsp.reconfig_addr   = out_reconf_reg.addr;
    assign rsp.reconfig_irq    = out_reconf_reg.irq;

    // A reconfiguration only comes from a claimed write, which never returns data
    a_reconf_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.reconfig |-> rsp.claimed && rsp.read_data == BYTE_NONE)
        else $error("reconfig on a word that is not a claimed write");

    // A read of the locked pair returns nothing
    a_locked_read: assert property (@(posedge clk) disable iff (!rst_n)
        proc && !is_write && locked_reg
            && (s1_port_reg == PORT_MAIN_INDEX || s1_port_reg == PORT_MAIN_DATA)
        |=> out_rd_reg == BYTE_NONE)
        else $error("locked pair returned data");

    // The unlock key opens the pair
    a_unlock: assert property (@(posedge clk) disable iff (!rst_n)
        proc && is_write && locked_reg && s1_port_reg == PORT_MAIN_INDEX
            && s1_data_reg == KEY_UNLOCK
        |=> !locked_reg)
        else $error("unlock key ignored");

    // The main index moves only on a processed word
    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(main_index_reg))
        else $error("main index moved without a word");

endmodule
